### hw/rtl/fcrc_pkg.sv
// Package for the framed CRC-16 block: frame length, polynomial, result kinds
// and the control struct passed to the frame CRC unit. No dependencies.
`default_nettype none

package fcrc_pkg;

	localparam int unsigned FrameBits = 100;
	localparam logic [6:0] FRAME_LAST_BIT = 7'(FrameBits - 1);
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic KIND_CRC = 1'b0;
	localparam logic KIND_SUM = 1'b1;

	typedef struct packed {
		logic shift;
		logic clear;
		logic bit_in;
	} frame_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/fcrc_if.sv
// Word channels of the framed CRC-16 block: byte input and result output.
// Depends on nothing.
`default_nettype none

interface fcrc_in_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface fcrc_out_if;
	logic valid;
	logic ready;
	logic result_kind;
	logic [15:0] result_value;
	logic run_last;

	modport source (output valid, output result_kind, output result_value,
		output run_last, input ready);
	modport sink (input valid, input result_kind, input result_value,
		input run_last, output ready);
endinterface

`default_nettype wire

### hw/rtl/fcrc_frame.sv
// Bit-serial CRC-16 unit: running remainder and bit count of the current frame.
// Depends on fcrc_pkg.
`default_nettype none

module fcrc_frame (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire fcrc_pkg::frame_ctrl_t ctrl,
	output logic [15:0]               crc_next,
	output logic                      fill
);

	logic [15:0] crc_q;
	logic [6:0]  bits_q;
	logic [15:0] mix;

	assign mix      = crc_q ^ {ctrl.bit_in, 15'd0};
	assign crc_next = mix[15] ? ({mix[14:0], 1'b0} ^ fcrc_pkg::CRC_POLY) : {mix[14:0], 1'b0};
	assign fill     = (bits_q == fcrc_pkg::FRAME_LAST_BIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= '0;
			bits_q <= '0;
		end else if (ctrl.clear || (ctrl.shift && fill)) begin
			crc_q  <= '0;
			bits_q <= '0;
		end else if (ctrl.shift) begin
			crc_q  <= crc_next;
			bits_q <= bits_q + 7'd1;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/frame_crc16_with_checksum_top.sv
// Framed CRC-16 (polynomial 0x1021, zero init) with a final checksum over all frame CRCs.
// Depends on fcrc_pkg, fcrc_if and fcrc_frame.
//
// Each byte is shifted through the CRC one bit per clock unless a frame CRC waits for the
// output register, and the next byte is taken as the last bit of the current one shifts.
// A frame CRC that cannot enter the full output register holds the shift until the
// register frees. On the last byte a partial frame is padded with zero bits at one bit per
// cycle, and the checksum follows from its own state once the output register can take it.
`default_nettype none

module frame_crc16_with_checksum_top (
	input  wire logic clk,
	input  wire logic arst_n,
	fcrc_in_if.sink   byte_ch,
	fcrc_out_if.source res_ch
);

	typedef enum logic [1:0] {ST_IDLE, ST_SHIFT, ST_PAD, ST_SUM} state_t;

	state_t      state_q;
	logic [7:0]  data_q;
	logic        last_q;
	logic [2:0]  bit_idx_q;
	logic [15:0] sum_q;
	logic        res_valid_q;
	logic        res_kind_q;
	logic [15:0] res_value_q;
	logic        res_last_q;

	fcrc_pkg::frame_ctrl_t frame_ctrl;
	logic [15:0] crc_next;
	logic        fill;
	logic        can_load;
	logic        step;
	logic        emit_crc;
	logic        emit_sum;
	logic        in_fire;
	logic [16:0] sum_add;
	logic [15:0] sum_next;

	assign can_load = !res_valid_q || res_ch.ready;
	assign step     = ((state_q == ST_SHIFT) || (state_q == ST_PAD)) && (!fill || can_load);
	assign emit_crc = step && fill;
	assign emit_sum = (state_q == ST_SUM) && can_load;

	assign frame_ctrl.shift  = step;
	assign frame_ctrl.clear  = emit_sum;
	assign frame_ctrl.bit_in = (state_q == ST_SHIFT) ? data_q[7] : 1'b0;

	fcrc_frame u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (frame_ctrl),
		.crc_next (crc_next),
		.fill     (fill)
	);

	assign sum_add  = {1'b0, sum_q} + {1'b0, crc_next};
	assign sum_next = sum_add[15:0] + {15'd0, sum_add[16]};

	assign byte_ch.ready = (state_q == ST_IDLE) ||
		((state_q == ST_SHIFT) && (bit_idx_q == 3'd0) && !last_q && step);
	assign in_fire = byte_ch.valid && byte_ch.ready;

	assign res_ch.valid        = res_valid_q;
	assign res_ch.result_kind  = res_kind_q;
	assign res_ch.result_value = res_value_q;
	assign res_ch.run_last     = res_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			data_q      <= '0;
			last_q      <= 1'b0;
			bit_idx_q   <= '0;
			sum_q       <= '0;
			res_valid_q <= 1'b0;
			res_kind_q  <= fcrc_pkg::KIND_CRC;
			res_value_q <= '0;
			res_last_q  <= 1'b0;
		end else begin
			if (emit_crc || emit_sum) begin
				res_valid_q <= 1'b1;
			end else if (res_ch.ready) begin
				res_valid_q <= 1'b0;
			end
			if (emit_crc) begin
				res_kind_q  <= fcrc_pkg::KIND_CRC;
				res_value_q <= crc_next;
				res_last_q  <= (state_q == ST_SHIFT) && !last_q;
				sum_q       <= sum_next;
			end
			if (in_fire) begin
				data_q    <= byte_ch.data_byte;
				last_q    <= byte_ch.last_byte;
				bit_idx_q <= 3'd7;
				state_q   <= ST_SHIFT;
			end else begin
				case (state_q)
					ST_SHIFT: begin
						if (step) begin
							data_q    <= {data_q[6:0], 1'b0};
							bit_idx_q <= bit_idx_q - 3'd1;
							if (bit_idx_q == 3'd0) begin
								if (!last_q) begin
									state_q <= ST_IDLE;
								end else if (fill) begin
									state_q <= ST_SUM;
								end else begin
									state_q <= ST_PAD;
								end
							end
						end
					end
					ST_PAD: begin
						if (emit_crc) begin
							state_q <= ST_SUM;
						end
					end
					ST_SUM: begin
						if (emit_sum) begin
							res_kind_q  <= fcrc_pkg::KIND_SUM;
							res_value_q <= ~sum_q + 16'd1;
							res_last_q  <= 1'b1;
							sum_q       <= '0;
							state_q     <= ST_IDLE;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/fcrc_checker.sv
// Port-level assertions for the framed CRC-16 block and the bind that attaches them.
// Depends on frame_crc16_with_checksum_top and fcrc_pkg.
`default_nettype none

module fcrc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        out_kind,
	input wire logic [15:0] out_value,
	input wire logic        out_last
);

	// A result held back by the sink keeps its kind and value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_kind))
		else $error("stalled result changed");

	// The checksum always closes the run of results of its byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == fcrc_pkg::KIND_SUM) |-> out_last)
		else $error("checksum without run_last");

	// A byte is shifted in one bit at a time, so two bytes never enter back to back.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !(in_valid && in_ready))
		else $error("bytes accepted in consecutive cycles");

endmodule

bind frame_crc16_with_checksum_top fcrc_checker u_fcrc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (byte_ch.valid),
	.in_ready  (byte_ch.ready),
	.out_valid (res_ch.valid),
	.out_ready (res_ch.ready),
	.out_kind  (res_ch.result_kind),
	.out_value (res_ch.result_value),
	.out_last  (res_ch.run_last)
);

`default_nettype wire

### sim/tb_frame_crc16_with_checksum_top.sv
// Testbench for the framed CRC-16 block with its closing checksum over all frame CRCs.
// Streams byte messages through the block and checks every result word against
// a bit-serial prediction. Depends on fcrc_pkg, fcrc_if and frame_crc16_with_checksum_top.

module tb_frame_crc16_with_checksum_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] data;
		logic last;
	} byte_word_t;

	typedef struct packed {
		logic kind;
		logic [15:0] value;
		logic run_last;
	} result_word_t;

	typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_ALT} fill_t;

	localparam int StallLimit = 3000;
	localparam int HoldOffCycles = 400;
	localparam int DrainCycles = fcrc_pkg::FrameBits + 32;
	localparam int PhaseBytes = 100;

	logic clk = 1'b0;
	logic arst_n;

	fcrc_in_if byte_ch ();
	fcrc_out_if res_ch ();

	frame_crc16_with_checksum_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_ch(byte_ch),
		.res_ch(res_ch)
	);

	always #5 clk = ~clk;

	logic [15:0] frame_crc;
	logic [6:0] frame_fill;
	logic [15:0] crc_total;
	result_word_t batch_words [3];
	int batch_count;

	byte_word_t pending_bytes [$];
	result_word_t expected_results [$];
	byte_word_t next_word;

	int send_idle_pct;
	int recv_stall_pct;
	logic hold_toggle;
	logic hold_seen;
	int hold_left;
	int quiet_cycles;
	int bytes_queued;
	int bytes_taken;
	int crcs_checked;
	int sums_checked;
	int mismatches;

	function automatic void shift_crc(input logic b);
		logic feedback;
		feedback = frame_crc[15] ^ b;
		frame_crc = {frame_crc[14:0], 1'b0} ^ (feedback ? fcrc_pkg::CRC_POLY : 16'h0000);
	endfunction

	function automatic void close_frame();
		logic [16:0] total;
		batch_words[batch_count] = '{fcrc_pkg::KIND_CRC, frame_crc, 1'b0};
		batch_count++;
		total = {1'b0, crc_total} + {1'b0, frame_crc};
		crc_total = total[15:0] + 16'(total[16]);
		frame_crc = '0;
		frame_fill = '0;
	endfunction

	function automatic void predict_byte(input logic [7:0] data, input logic last);
		batch_count = 0;
		for (int i = 7; i >= 0; i--) begin
			shift_crc(data[i]);
			frame_fill = frame_fill + 7'd1;
			if (int'(frame_fill) >= fcrc_pkg::FrameBits) begin
				close_frame();
			end
		end
		if (last) begin
			if (frame_fill != '0) begin
				while (int'(frame_fill) < fcrc_pkg::FrameBits) begin
					shift_crc(1'b0);
					frame_fill = frame_fill + 7'd1;
				end
				close_frame();
			end
			batch_words[batch_count] = '{fcrc_pkg::KIND_SUM, 16'(~crc_total + 16'd1), 1'b0};
			batch_count++;
			frame_crc = '0;
			frame_fill = '0;
			crc_total = '0;
		end
		if (batch_count > 0) begin
			batch_words[batch_count - 1].run_last = 1'b1;
		end
		for (int k = 0; k < batch_count; k++) begin
			expected_results.insert(expected_results.size(), batch_words[k]);
		end
	endfunction

	function automatic void check_result(input result_word_t got);
		result_word_t want;
		if (expected_results.size() == 0) begin
			$display("%0t: unexpected result: kind %0b value %h run_last %0b",
				$time, got.kind, got.value, got.run_last);
			mismatches++;
			return;
		end
		want = expected_results.pop_front();
		if (got.kind !== want.kind) begin
			$display("%0t: result_kind expected %0b, actual %0b", $time, want.kind, got.kind);
			mismatches++;
		end
		if (got.value !== want.value) begin
			$display("%0t: result_value expected %h, actual %h", $time, want.value, got.value);
			mismatches++;
		end
		if (got.run_last !== want.run_last) begin
			$display("%0t: run_last expected %0b, actual %0b",
				$time, want.run_last, got.run_last);
			mismatches++;
		end
		if (want.kind == fcrc_pkg::KIND_SUM) begin
			sums_checked++;
		end else begin
			crcs_checked++;
		end
	endfunction

	task automatic add_message(input int len, input fill_t pattern);
		byte_word_t w;
		for (int i = 0; i < len; i++) begin
			case (pattern)
				FILL_ZERO: w.data = 8'h00;
				FILL_ONES: w.data = 8'hFF;
				FILL_ALT: w.data = i[0] ? 8'h5A : 8'hA5;
				default: w.data = 8'($urandom);
			endcase
			w.last = (i == len - 1);
			pending_bytes.insert(pending_bytes.size(), w);
			bytes_queued++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_ch.valid <= 1'b0;
			byte_ch.data_byte <= '0;
			byte_ch.last_byte <= 1'b0;
			frame_crc = '0;
			frame_fill = '0;
			crc_total = '0;
		end else begin
			if (byte_ch.valid && byte_ch.ready) begin
				predict_byte(byte_ch.data_byte, byte_ch.last_byte);
				bytes_taken++;
			end
			if (!byte_ch.valid || byte_ch.ready) begin
				if (pending_bytes.size() > 0 && int'($urandom_range(99)) >= send_idle_pct) begin
					next_word = pending_bytes.pop_front();
					byte_ch.valid <= 1'b1;
					byte_ch.data_byte <= next_word.data;
					byte_ch.last_byte <= next_word.last;
				end else begin
					byte_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				check_result('{res_ch.result_kind, res_ch.result_value, res_ch.run_last});
			end
			res_ch.ready <= (hold_left == 0) && (int'($urandom_range(99)) >= recv_stall_pct);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_seen <= 1'b0;
			hold_left <= 0;
		end else if (hold_toggle != hold_seen) begin
			hold_seen <= hold_toggle;
			hold_left <= HoldOffCycles;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= StallLimit) begin
			$display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int boundary_len;
		int phase_start;
		int pick;
		int len;
		int send_pct [4];
		int recv_pct [4];
		fill_t pattern;

		send_pct = '{0, 62, 0, 11};
		recv_pct = '{0, 0, 62, 11};
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.last_byte = 1'b0;
		res_ch.ready = 1'b0;
		hold_toggle = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		bytes_queued = 0;
		bytes_taken = 0;
		crcs_checked = 0;
		sums_checked = 0;
		mismatches = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		boundary_len = 1;
		while ((boundary_len * 8) % fcrc_pkg::FrameBits != 0) begin
			boundary_len++;
		end

		// A lone byte of each extreme, then a message whose last byte both closes a
		// frame and leaves a partial one to pad.
		add_message(1, FILL_ONES);
		add_message(1, FILL_ZERO);
		add_message(fcrc_pkg::FrameBits / 8 + 1, FILL_ALT);
		add_message(3, FILL_RANDOM);

		for (int phase = 0; phase < 4; phase++) begin
			@(negedge clk);
			send_idle_pct = send_pct[phase];
			recv_stall_pct = recv_pct[phase];
			phase_start = bytes_queued;
			if (phase == 0) begin
				add_message(boundary_len, FILL_RANDOM);
			end
			while (bytes_queued - phase_start < PhaseBytes) begin
				pick = $urandom_range(99);
				if (pick < 35) begin
					len = $urandom_range(1, 4);
				end else if (pick < 65) begin
					len = $urandom_range(5, 30);
				end else if (pick < 85) begin
					len = boundary_len * $urandom_range(1, 2);
				end else begin
					len = $urandom_range(boundary_len - 1, boundary_len + 1);
				end
				pick = $urandom_range(9);
				pattern = (pick == 0) ? FILL_ZERO : (pick == 1) ? FILL_ONES : FILL_RANDOM;
				add_message(len, pattern);
			end
			if (phase == 0) begin
				hold_toggle = ~hold_toggle;
			end
			while (pending_bytes.size() > 0) begin
				@(negedge clk);
			end
		end

		while (byte_ch.valid) begin
			@(negedge clk);
		end
		recv_stall_pct = 0;
		while (expected_results.size() > 0) begin
			@(negedge clk);
		end
		repeat (DrainCycles) @(negedge clk);

		$display("Run covered %0d bytes in %0d messages,", bytes_taken, sums_checked);
		$display("checking %0d frame CRCs and %0d checksums,", crcs_checked, sums_checked);
		$display("under four idle and stall mixes and one long output hold-off.");
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

### filelist.f
hw/rtl/fcrc_pkg.sv
hw/rtl/fcrc_if.sv
hw/rtl/fcrc_frame.sv
hw/rtl/frame_crc16_with_checksum_top.sv
hw/rtl/fcrc_checker.sv
sim/tb_frame_crc16_with_checksum_top.sv
